// File: rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Holds the item structs, configuration register map and reset values.
`default_nettype none

package uer_pkg;

  localparam int unsigned TimeBitsDefault = 32;

  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned CfgDataBits  = 20;

  localparam logic [CfgIndexBits-1:0] CFG_MM_PER_US   = 3'd0;
  localparam logic [CfgIndexBits-1:0] CFG_MIN_DIST    = 3'd1;
  localparam logic [CfgIndexBits-1:0] CFG_MAX_DIST    = 3'd2;
  localparam logic [CfgIndexBits-1:0] CFG_ECHO_TMO    = 3'd3;
  localparam logic [CfgIndexBits-1:0] CFG_START_TMO   = 3'd4;
  localparam logic [CfgIndexBits-1:0] CFG_MIN_INTERVAL = 3'd5;
  localparam logic [CfgIndexBits-1:0] CFG_TRIG_WIDTH  = 3'd6;

  localparam logic [15:0] MmPerUsReset     = 16'd11239;
  localparam logic [15:0] MinDistReset     = 16'd20;
  localparam logic [15:0] MaxDistReset     = 16'd4000;
  localparam logic [15:0] EchoTmoReset     = 16'd30000;
  localparam logic [15:0] StartTmoReset    = 16'd10000;
  localparam logic [19:0] MinIntervalReset = 20'd60000;
  localparam logic [7:0]  TrigWidthReset   = 8'd10;

  localparam int unsigned CountBits = 17;

  typedef struct packed {
    logic [15:0] mm_per_us_q16;
    logic [15:0] min_distance_mm;
    logic [15:0] max_distance_mm;
    logic [15:0] echo_timeout_us;
    logic [15:0] start_timeout_us;
    logic [19:0] min_interval_us;
    logic [7:0]  trigger_width_us;
  } cfg_t;

  typedef struct packed {
    logic echo_level;
    logic read_request;
  } in_item_t;

  typedef struct packed {
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic [15:0] distance_mm;
    logic        fresh;
  } out_item_t;

  typedef struct packed {
    logic [15:0] mm;
    logic        ok;
  } scale_res_t;

endpackage

`default_nettype wire

// File: rtl/ultrasonic_echo_ranger_core.sv
// Top level of the ultrasonic echo ranger: sequencer, timestamps, result register.
// Depends on uer_pkg, uer_cfg and uer_scale.
`default_nettype none

// One input item is one microsecond tick and yields exactly one result item.
// Items are taken at one per clock cycle unless a result waits with out_ready
// low; each result appears in the output register in the cycle after its item
// is accepted, and the next item is taken in the same cycle that a waiting
// result is taken. The sequencer state, timestamps and held distance advance
// only on accepted items, so stalls on either side do not shift time. The echo
// width is scaled by a single 17x16 multiplier and range compare in the accept cycle.
module ultrasonic_echo_ranger_core #(
  parameter int unsigned TIME_BITS = uer_pkg::TimeBitsDefault
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire uer_pkg::in_item_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output uer_pkg::out_item_t                    out_data,
  input  wire logic                             cfg_en,
  input  wire logic [uer_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [uer_pkg::CfgDataBits-1:0]  cfg_data
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_RISE = 2'd2;
  localparam logic [1:0] PH_MEAS = 2'd3;

  localparam int unsigned CB = uer_pkg::CountBits;

  uer_pkg::cfg_t       cfg;
  uer_pkg::scale_res_t scale;

  logic [1:0]           phase, phase_next;
  logic [CB-1:0]        phase_counter, phase_counter_next;
  logic [TIME_BITS-1:0] time_now, request_time, request_time_next;
  logic [TIME_BITS-1:0] last_success_time, last_success_time_next;
  logic [15:0]          held_distance, held_distance_next;
  uer_pkg::out_item_t   res_next;

  logic                 accept;
  logic [TIME_BITS-1:0] elapsed;
  logic                 early;
  logic [CB-1:0]        cnt_inc;
  logic [CB-1:0]        width_target;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uer_scale u_scale (
    .width (phase_counter),
    .cfg   (cfg),
    .res   (scale)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign elapsed = time_now - last_success_time;
  assign early   = (elapsed < TIME_BITS'(cfg.min_interval_us));
  assign cnt_inc = phase_counter + CB'(1);
  assign width_target = (cfg.trigger_width_us == 8'd0) ? CB'(1)
                                                       : CB'(cfg.trigger_width_us);

  always_comb begin
    phase_next              = phase;
    phase_counter_next      = phase_counter;
    request_time_next       = request_time;
    last_success_time_next  = last_success_time;
    held_distance_next      = held_distance;
    res_next                = '0;

    case (phase)
      PH_IDLE: begin
        if (in_data.read_request) begin
          if (early) begin
            res_next.done_res    = 1'b1;
            res_next.distance_mm = held_distance;
          end else begin
            request_time_next      = time_now;
            res_next.trigger_level = 1'b1;
            if (width_target <= CB'(1)) begin
              phase_next         = PH_RISE;
              phase_counter_next = '0;
            end else begin
              phase_next         = PH_TRIG;
              phase_counter_next = CB'(1);
            end
          end
        end
      end
      PH_TRIG: begin
        res_next.trigger_level = 1'b1;
        phase_counter_next     = cnt_inc;
        if (cnt_inc >= width_target) begin
          phase_next         = PH_RISE;
          phase_counter_next = '0;
        end
      end
      PH_RISE: begin
        if (in_data.echo_level) begin
          phase_next         = PH_MEAS;
          phase_counter_next = '0;
        end else begin
          phase_counter_next = cnt_inc;
          if (cnt_inc > CB'(cfg.start_timeout_us)) begin
            phase_next           = PH_IDLE;
            phase_counter_next   = '0;
            res_next.done_res    = 1'b1;
            res_next.distance_mm = held_distance;
          end
        end
      end
      PH_MEAS: begin
        if (in_data.echo_level) begin
          phase_counter_next = cnt_inc;
          if (cnt_inc > CB'(cfg.echo_timeout_us)) begin
            phase_next           = PH_IDLE;
            phase_counter_next   = '0;
            res_next.done_res    = 1'b1;
            res_next.distance_mm = held_distance;
          end
        end else begin
          res_next.done_res    = 1'b1;
          res_next.distance_mm = held_distance;
          if (scale.ok) begin
            held_distance_next     = scale.mm;
            last_success_time_next = request_time;
            res_next.distance_mm   = scale.mm;
            res_next.fresh         = 1'b1;
          end
          phase_next         = PH_IDLE;
          phase_counter_next = '0;
        end
      end
      default: ;
    endcase

    res_next.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      phase_counter     <= '0;
      time_now          <= '0;
      request_time      <= '0;
      last_success_time <= '0;
      held_distance     <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      phase_counter     <= phase_counter_next;
      time_now          <= time_now + TIME_BITS'(1);
      request_time      <= request_time_next;
      last_success_time <= last_success_time_next;
      held_distance     <= held_distance_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/uer_cfg.sv
// Configuration register file for the ultrasonic echo ranger.
// Depends on uer_pkg for the register map and reset values.
`default_nettype none

module uer_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_en,
  input  wire logic [uer_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [uer_pkg::CfgDataBits-1:0]  cfg_data,
  output uer_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mm_per_us_q16    <= uer_pkg::MmPerUsReset;
      cfg.min_distance_mm  <= uer_pkg::MinDistReset;
      cfg.max_distance_mm  <= uer_pkg::MaxDistReset;
      cfg.echo_timeout_us  <= uer_pkg::EchoTmoReset;
      cfg.start_timeout_us <= uer_pkg::StartTmoReset;
      cfg.min_interval_us  <= uer_pkg::MinIntervalReset;
      cfg.trigger_width_us <= uer_pkg::TrigWidthReset;
    end else if (cfg_en) begin
      case (cfg_index)
        uer_pkg::CFG_MM_PER_US:    cfg.mm_per_us_q16    <= cfg_data[15:0];
        uer_pkg::CFG_MIN_DIST:     cfg.min_distance_mm  <= cfg_data[15:0];
        uer_pkg::CFG_MAX_DIST:     cfg.max_distance_mm  <= cfg_data[15:0];
        uer_pkg::CFG_ECHO_TMO:     cfg.echo_timeout_us  <= cfg_data[15:0];
        uer_pkg::CFG_START_TMO:    cfg.start_timeout_us <= cfg_data[15:0];
        uer_pkg::CFG_MIN_INTERVAL: cfg.min_interval_us  <= cfg_data[19:0];
        uer_pkg::CFG_TRIG_WIDTH:   cfg.trigger_width_us <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/uer_scale.sv
// Echo width to millimetres: Q0.16 product, truncation and range check.
// Depends on uer_pkg for the configuration and result structs.
`default_nettype none

module uer_scale (
  input  wire logic [uer_pkg::CountBits-1:0] width,
  input  wire uer_pkg::cfg_t                 cfg,
  output uer_pkg::scale_res_t                res
);

  logic [uer_pkg::CountBits+15:0] prod;
  logic [uer_pkg::CountBits-1:0]  mm_full;

  assign prod    = width * cfg.mm_per_us_q16;
  assign mm_full = prod[uer_pkg::CountBits+15:16];

  assign res.mm = mm_full[15:0];
  assign res.ok = (width != '0)
               && (mm_full >= {1'b0, cfg.min_distance_mm})
               && (mm_full <= {1'b0, cfg.max_distance_mm});

endmodule

`default_nettype wire
